[sv/brpd_pkg.sv]
// ----------------------------------------------------------------------------
// brpd_pkg
// Shared sizes, codes and types of the latching relay pulse driver.
// ----------------------------------------------------------------------------
package brpd_pkg;

    localparam int RELAY_COUNT = 19;
    localparam int RIDX_W      = (RELAY_COUNT > 1) ? $clog2(RELAY_COUNT) : 1;
    localparam int IN_IDX_W    = 5;
    localparam int CMD_W       = 2;
    localparam int HOLD_W      = 10;
    localparam int OUT_W       = 19;
    localparam int PAD_W       = (RELAY_COUNT > OUT_W) ? RELAY_COUNT : OUT_W;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 10'd25;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // words in flight: queue, back end, result slot
    localparam int MAX_OUTSTANDING = QUEUE_DEPTH + 2;
    localparam int OUTS_W          = $clog2(MAX_OUTSTANDING + 1);

    localparam logic FUNC_REQUEST = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_OFF    = 2'd0,
        CMD_ON     = 2'd1,
        CMD_TOGGLE = 2'd2,
        CMD_ON_ALT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        POS_OFF,
        POS_ON,
        POS_UNKNOWN
    } pos_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ON,
        OP_OFF,
        OP_TOGGLE,
        OP_TICK
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [RIDX_W-1:0] idx;
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_TICK,
        BK_REPORT
    } bk_state_t;

    typedef struct packed {
        logic [OUT_W-1:0] set_coils;
        logic [OUT_W-1:0] reset_coils;
        logic             busy;
    } res_t;

endpackage

[sv/brpd_front.sv]
// ----------------------------------------------------------------------------
// brpd_front
// Accepts input words, classifies them into operations and queues them.
// ----------------------------------------------------------------------------
module brpd_front
    import brpd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                func,
    input  logic [IN_IDX_W-1:0] relay_index,
    input  logic [CMD_W-1:0]    command,
    output logic                op_valid,
    output op_t                 op,
    input  logic                op_pop
);

    op_t               q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    op_t               op_in;
    logic              in_range;
    logic              wr_en;
    logic              rd_en;

    assign in_range = {1'b0, relay_index} < (IN_IDX_W + 1)'(RELAY_COUNT);

    always_comb
    begin
        op_in.idx = relay_index[RIDX_W-1:0];
        if (func == FUNC_TICK)
        begin
            op_in.kind = OP_TICK;
        end
        else if (!in_range)
        begin
            op_in.kind = OP_NOP;
        end
        else
        begin
            case (cmd_t'(command))
                CMD_OFF:    op_in.kind = OP_OFF;
                CMD_TOGGLE: op_in.kind = OP_TOGGLE;
                default:    op_in.kind = OP_ON;
            endcase
        end
    end

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign op_valid = (cnt_reg != '0);
    assign op       = q_mem_reg[rd_ptr_reg];
    assign wr_en    = push && !full;
    assign rd_en    = op_pop && op_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

[sv/brpd_back.sv]
// ----------------------------------------------------------------------------
// brpd_back
// Executes queued operations on the relay state and holds the result word.
// ----------------------------------------------------------------------------
module brpd_back
    import brpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [HOLD_W-1:0] hold_ticks,
    input  logic              op_valid,
    input  op_t               op,
    output logic              op_pop,
    output logic              res_valid,
    output res_t              res,
    input  logic              res_pop
);

    bk_state_t         state_reg, state_next;
    logic [RIDX_W-1:0] cnt_reg, cnt_next;

    pos_t              pos_reg   [RELAY_COUNT];
    logic [HOLD_W-1:0] set_t_reg [RELAY_COUNT];
    logic [HOLD_W-1:0] rst_t_reg [RELAY_COUNT];
    logic [RELAY_COUNT-1:0] set_run_reg, rst_run_reg;
    logic [RELAY_COUNT-1:0] set_lvl_reg, rst_lvl_reg;

    res_t res_reg, res_next;
    logic res_valid_reg, res_valid_next;

    logic req_go, tick_go, load_res, last_relay;

    logic [RIDX_W-1:0] addr;
    pos_t              cur_pos, nxt_pos;
    logic [HOLD_W-1:0] cur_set_t, cur_rst_t, nxt_set_t, nxt_rst_t;
    logic              nxt_set_lvl, nxt_rst_lvl;
    logic              want_on, we;
    logic [PAD_W-1:0]  set_pad, rst_pad;

    assign last_relay = (cnt_reg == RIDX_W'(RELAY_COUNT - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (op_valid && !res_valid_reg)
                begin
                    state_next = (op.kind == OP_TICK) ? BK_TICK : BK_REPORT;
                end
            end
            BK_TICK:
            begin
                if (last_relay)
                begin
                    state_next = BK_REPORT;
                end
            end
            BK_REPORT: state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        op_pop   = 1'b0;
        req_go   = 1'b0;
        tick_go  = 1'b0;
        load_res = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                op_pop = op_valid && !res_valid_reg;
                req_go = op_valid && !res_valid_reg && (op.kind != OP_TICK)
                         && (op.kind != OP_NOP);
            end
            BK_TICK:   tick_go  = 1'b1;
            BK_REPORT: load_res = 1'b1;
            default:   op_pop   = 1'b0;
        endcase
    end

    always_comb
    begin
        cnt_next = '0;
        if (tick_go && !last_relay)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // one relay per cycle: the request's relay, or the tick walk position
    assign addr      = tick_go ? cnt_reg : op.idx;
    assign cur_pos   = pos_reg[addr];
    assign cur_set_t = set_t_reg[addr];
    assign cur_rst_t = rst_t_reg[addr];

    always_comb
    begin
        case (op.kind)
            OP_ON:     want_on = 1'b1;
            OP_TOGGLE: want_on = (cur_pos == POS_OFF);
            default:   want_on = 1'b0;
        endcase
    end

    always_comb
    begin
        nxt_pos     = cur_pos;
        nxt_set_t   = cur_set_t;
        nxt_rst_t   = cur_rst_t;
        nxt_set_lvl = set_lvl_reg[addr];
        nxt_rst_lvl = rst_lvl_reg[addr];
        if (req_go)
        begin
            if (want_on)
            begin
                if (cur_pos != POS_ON)
                begin
                    nxt_set_t = hold_ticks;
                    nxt_pos   = POS_ON;
                end
            end
            else if (cur_pos != POS_OFF)
            begin
                nxt_rst_t = hold_ticks;
                nxt_pos   = POS_OFF;
            end
        end
        if (tick_go)
        begin
            // raise at hold, drop at one; drop wins for a one-tick pulse
            if (cur_set_t != '0)
            begin
                if (cur_set_t == hold_ticks)
                begin
                    nxt_set_lvl = 1'b1;
                end
                if (cur_set_t == HOLD_W'(1))
                begin
                    nxt_set_lvl = 1'b0;
                end
                nxt_set_t = cur_set_t - 1'b1;
            end
            if (cur_rst_t != '0)
            begin
                if (cur_rst_t == hold_ticks)
                begin
                    nxt_rst_lvl = 1'b1;
                end
                if (cur_rst_t == HOLD_W'(1))
                begin
                    nxt_rst_lvl = 1'b0;
                end
                nxt_rst_t = cur_rst_t - 1'b1;
            end
        end
    end

    assign we = req_go || tick_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RELAY_COUNT; i++)
            begin
                pos_reg[i]   <= POS_UNKNOWN;
                set_t_reg[i] <= '0;
                rst_t_reg[i] <= '0;
            end
            set_run_reg <= '0;
            rst_run_reg <= '0;
            set_lvl_reg <= '0;
            rst_lvl_reg <= '0;
        end
        else if (we)
        begin
            pos_reg[addr]     <= nxt_pos;
            set_t_reg[addr]   <= nxt_set_t;
            rst_t_reg[addr]   <= nxt_rst_t;
            set_run_reg[addr] <= (nxt_set_t != '0);
            rst_run_reg[addr] <= (nxt_rst_t != '0);
            set_lvl_reg[addr] <= nxt_set_lvl;
            rst_lvl_reg[addr] <= nxt_rst_lvl;
        end
    end

    assign set_pad = PAD_W'(set_lvl_reg);
    assign rst_pad = PAD_W'(rst_lvl_reg);

    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (load_res)
        begin
            res_next.set_coils   = set_pad[OUT_W-1:0];
            res_next.reset_coils = rst_pad[OUT_W-1:0];
            res_next.busy        = (|set_run_reg) || (|rst_run_reg);
            res_valid_next       = 1'b1;
        end
        else if (res_pop)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[sv/bistable_relay_pulse_driver_core.sv]
// ----------------------------------------------------------------------------
// bistable_relay_pulse_driver_core
// Pulse driver for a bank of latching relays with set and reset coils.
// ----------------------------------------------------------------------------
// A switch request passes the back end through its idle and report states; a tick
// also passes the tick state between them, which walks the timer bank one relay per
// cycle. Words wait in a two-entry queue in front of the back end, and each
// result sits in a one-word output slot; the back end starts the next word once
// that slot has been popped. hold_ticks resets to 25 and is written through the
// cfg channel, which is always ready; write it only while no word is pending.
// ----------------------------------------------------------------------------
module bistable_relay_pulse_driver_core
    import brpd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                func,
    input  logic [IN_IDX_W-1:0] relay_index,
    input  logic [CMD_W-1:0]    command,
    output logic                empty,
    input  logic                pop,
    output logic [OUT_W-1:0]    set_coils,
    output logic [OUT_W-1:0]    reset_coils,
    output logic                busy_res,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [HOLD_W-1:0]   cfg_data
);

    logic [HOLD_W-1:0] hold_ticks_reg;
    logic              op_valid;
    op_t               op;
    logic              op_pop;
    logic              res_valid;
    res_t              res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg <= HOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            hold_ticks_reg <= cfg_data;
        end
    end

    brpd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .func        (func),
        .relay_index (relay_index),
        .command     (command),
        .op_valid    (op_valid),
        .op          (op),
        .op_pop      (op_pop)
    );

    brpd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold_ticks (hold_ticks_reg),
        .op_valid   (op_valid),
        .op         (op),
        .op_pop     (op_pop),
        .res_valid  (res_valid),
        .res        (res),
        .res_pop    (pop && res_valid)
    );

    assign empty       = !res_valid;
    assign set_coils   = res.set_coils;
    assign reset_coils = res.reset_coils;
    assign busy_res    = res.busy;

endmodule

[sv/brpd_checker.sv]
// ----------------------------------------------------------------------------
// brpd_checker
// Port-level checks of the relay pulse driver, bound to the top level.
// ----------------------------------------------------------------------------
module brpd_checker
    import brpd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             push,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input logic [OUT_W-1:0] set_coils,
    input logic [OUT_W-1:0] reset_coils,
    input logic             busy_res
);

    logic [OUTS_W-1:0] outs_reg, outs_next;
    logic              in_acc, out_acc;

    assign in_acc  = push && !full;
    assign out_acc = pop && !empty;

    // words accepted but not yet popped
    always_comb
    begin
        outs_next = outs_reg;
        if (in_acc && !out_acc)
        begin
            outs_next = outs_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            outs_next = outs_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outs_reg <= '0;
        end
        else
        begin
            outs_reg <= outs_next;
        end
    end

    a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> outs_reg != '0)
        else $error("result shown with no word outstanding");

    a_full_means_queued: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> outs_reg >= OUTS_W'(QUEUE_DEPTH))
        else $error("full raised with queue not filled");

    a_bounded_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        outs_reg <= OUTS_W'(MAX_OUTSTANDING))
        else $error("more words in flight than storage allows");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(set_coils) && $stable(reset_coils)
                              && $stable(busy_res)))
        else $error("waiting result changed before pop");

endmodule

bind bistable_relay_pulse_driver_core brpd_checker u_brpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .set_coils   (set_coils),
    .reset_coils (reset_coils),
    .busy_res    (busy_res)
);

[dv/tb_bistable_relay_pulse_driver_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bistable_relay_pulse_driver_core
// Self-checking bench for the latching relay pulse driver. A queue-fed driver
// pushes switch requests and ticks, a word-level model of the relay bank
// predicts every result word, and a monitor compares each popped word.
// hold_ticks is rewritten between phases while the pipe is drained, and each
// phase sets one of four sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_bistable_relay_pulse_driver_core;
    import brpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int NUM_PHASES     = 8;

    typedef struct {
        logic                f;
        logic [IN_IDX_W-1:0] idx;
        logic [CMD_W-1:0]    cmd;
    } word_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                push        = 1'b0;
    logic                full;
    logic                func        = FUNC_REQUEST;
    logic [IN_IDX_W-1:0] relay_index = '0;
    logic [CMD_W-1:0]    command     = CMD_OFF;
    logic                empty;
    logic                pop         = 1'b0;
    logic [OUT_W-1:0]    set_coils;
    logic [OUT_W-1:0]    reset_coils;
    logic                busy_res;
    logic                cfg_valid   = 1'b0;
    logic                cfg_ready;
    logic [HOLD_W-1:0]   cfg_data    = HOLD_RESET;

    bistable_relay_pulse_driver_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .func        (func),
        .relay_index (relay_index),
        .command     (command),
        .empty       (empty),
        .pop         (pop),
        .set_coils   (set_coils),
        .reset_coils (reset_coils),
        .busy_res    (busy_res),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // relay bank model
    pos_t              relay_pos [RELAY_COUNT];
    logic [HOLD_W-1:0] set_tmr   [RELAY_COUNT];
    logic [HOLD_W-1:0] rst_tmr   [RELAY_COUNT];
    logic [PAD_W-1:0]  set_lvl;
    logic [PAD_W-1:0]  rst_lvl;
    logic [HOLD_W-1:0] hold_model;

    word_t pending_words [$];
    res_t  expected_coils [$];

    int send_idle_pct  = 0;
    int pop_stall_pct  = 0;
    int mismatches     = 0;
    int results_seen   = 0;
    int requests_taken = 0;
    int ignored_taken  = 0;
    int ticks_taken    = 0;
    int hold_writes    = 0;
    int stall_cycles   = 0;

    function automatic void step_timer(inout logic [HOLD_W-1:0] t, inout logic lvl);
        if (t != '0)
        begin
            if (t == hold_model)
                lvl = 1'b1;
            if (t == HOLD_W'(1))
                lvl = 1'b0;
            t = t - 1'b1;
        end
    endfunction

    function automatic res_t advance_bank(logic f, logic [IN_IDX_W-1:0] idx, cmd_t c);
        res_t r;
        logic want_on;
        logic any_run;
        any_run = 1'b0;
        if (f == FUNC_TICK)
        begin
            for (int i = 0; i < RELAY_COUNT; i++)
            begin
                step_timer(set_tmr[i], set_lvl[i]);
                step_timer(rst_tmr[i], rst_lvl[i]);
            end
        end
        else if (idx < RELAY_COUNT)
        begin
            if (c == CMD_TOGGLE)
                want_on = (relay_pos[idx] == POS_OFF);
            else
                want_on = (c != CMD_OFF);
            if (want_on && relay_pos[idx] != POS_ON)
            begin
                set_tmr[idx]   = hold_model;
                relay_pos[idx] = POS_ON;
            end
            else if (!want_on && relay_pos[idx] != POS_OFF)
            begin
                rst_tmr[idx]   = hold_model;
                relay_pos[idx] = POS_OFF;
            end
        end
        for (int i = 0; i < RELAY_COUNT; i++)
            if (set_tmr[i] != '0 || rst_tmr[i] != '0)
                any_run = 1'b1;
        r.set_coils   = set_lvl[OUT_W-1:0];
        r.reset_coils = rst_lvl[OUT_W-1:0];
        r.busy        = any_run;
        return r;
    endfunction

    task automatic log_error(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // driver: at most one nonblocking write of push per edge
    always @(posedge clk)
    begin : drv
        word_t nxt;
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                expected_coils.push_back(advance_bank(func, relay_index, cmd_t'(command)));
                if (func == FUNC_TICK)
                    ticks_taken++;
                else if (relay_index >= RELAY_COUNT)
                    ignored_taken++;
                else
                    requests_taken++;
            end
            if (!push || !full)
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_words.pop_front();
                    push        <= 1'b1;
                    func        <= nxt.f;
                    relay_index <= nxt.idx;
                    command     <= nxt.cmd;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : mon
        res_t e;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                results_seen++;
                if (expected_coils.size() == 0)
                    log_error($sformatf("unexpected word set=%05h reset=%05h busy=%0b",
                                        set_coils, reset_coils, busy_res));
                else
                begin
                    e = expected_coils.pop_front();
                    if (set_coils !== e.set_coils || reset_coils !== e.reset_coils ||
                        busy_res !== e.busy)
                        log_error($sformatf(
                            "word %0d: exp set=%05h reset=%05h busy=%0b, got set=%05h reset=%05h busy=%0b",
                            results_seen, e.set_coils, e.reset_coils, e.busy,
                            set_coils, reset_coils, busy_res));
                end
            end
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic void add_word(logic f, int idx, cmd_t c);
        word_t w;
        w.f   = f;
        w.idx = IN_IDX_W'(idx);
        w.cmd = c;
        pending_words.push_back(w);
    endfunction

    // mostly in-range requests and ticks, with tick runs of hold + 1, capped at 30,
    // that finish pulses of up to 30 ticks, plus some out-of-range noise
    task automatic add_random(int n, int hold);
        int r;
        int run;
        int k;
        k = 0;
        while (k < n)
        begin
            r = $urandom_range(99);
            if (r < 38)
            begin
                add_word(FUNC_TICK, $urandom_range(31), cmd_t'($urandom_range(3)));
                k++;
            end
            else if (r < 46)
            begin
                add_word(FUNC_REQUEST, $urandom_range(31, RELAY_COUNT),
                         cmd_t'($urandom_range(3)));
                k++;
            end
            else if (r < 50)
            begin
                run = (hold + 1 < 30) ? hold + 1 : 30;
                for (int j = 0; j < run; j++)
                    add_word(FUNC_TICK, $urandom_range(31), cmd_t'($urandom_range(3)));
                k += run;
            end
            else
            begin
                add_word(FUNC_REQUEST, $urandom_range(RELAY_COUNT - 1),
                         cmd_t'($urandom_range(3)));
                k++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || push || expected_coils.size() > 0)
            @(posedge clk);
    endtask

    task automatic write_hold(logic [HOLD_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        hold_model = v;
        hold_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idle_mode(int m);
        case (m % 4)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 48; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 48; end
            default: begin send_idle_pct = 11; pop_stall_pct = 11; end
        endcase
    endtask

    initial
    begin : stim
        int hold_plan [NUM_PHASES];
        int count_plan [NUM_PHASES];
        int h;
        hold_plan  = '{3, 1, 5, 1023, 2, 0, -1, 4};
        count_plan = '{150, 150, 150, 100, 150, 100, 200, 200};

        for (int i = 0; i < RELAY_COUNT; i++)
        begin
            relay_pos[i] = POS_UNKNOWN;
            set_tmr[i]   = '0;
            rst_tmr[i]   = '0;
        end
        set_lvl    = '0;
        rst_lvl    = '0;
        hold_model = HOLD_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset pulse length
        add_word(FUNC_TICK, 31, CMD_ON_ALT);       // tick with nothing running
        add_word(FUNC_REQUEST, 0, CMD_TOGGLE);     // unknown toggles to off
        add_word(FUNC_REQUEST, 1, CMD_ON);
        add_word(FUNC_REQUEST, 2, CMD_ON_ALT);     // command three acts as on
        add_word(FUNC_REQUEST, 0, CMD_OFF);        // already off, no reload
        add_word(FUNC_REQUEST, 18, CMD_OFF);
        add_word(FUNC_REQUEST, 19, CMD_ON);        // out of range
        add_word(FUNC_REQUEST, 31, CMD_TOGGLE);    // out of range
        add_word(FUNC_TICK, 0, CMD_OFF);           // coils rise
        add_word(FUNC_REQUEST, 1, CMD_OFF);        // reversal mid-pulse
        add_word(FUNC_REQUEST, 2, CMD_ON);         // same position mid-pulse
        add_word(FUNC_TICK, 0, CMD_OFF);
        add_word(FUNC_TICK, 0, CMD_OFF);
        add_word(FUNC_REQUEST, 0, CMD_TOGGLE);     // off toggles to on
        add_word(FUNC_REQUEST, 3, CMD_TOGGLE);
        add_word(FUNC_REQUEST, 1, CMD_TOGGLE);     // on again, reset pulse still running
        for (int j = 0; j < 8; j++)
            add_word(FUNC_TICK, 0, CMD_OFF);
        set_idle_mode(0);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            h = (hold_plan[p] < 0) ? $urandom_range(40, 6) : hold_plan[p];
            write_hold(HOLD_W'(h));
            set_idle_mode(p);
            add_random(count_plan[p], h);
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (expected_coils.size() != 0)
            log_error($sformatf("%0d words never arrived", expected_coils.size()));

        $display("Ran %0d switch requests (%0d out of range) and %0d ticks over %0d hold settings;",
                 requests_taken + ignored_taken, ignored_taken, ticks_taken, hold_writes);
        $display("%0d result words checked, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
sv/brpd_pkg.sv
sv/brpd_front.sv
sv/brpd_back.sv
sv/bistable_relay_pulse_driver_core.sv
sv/brpd_checker.sv
dv/tb_bistable_relay_pulse_driver_core.sv
